### rtl/core/mtep_pkg.sv
// Package of shared types and constants for the MIDI track event parser.
package mtep_pkg;

    localparam int unsigned MAX_VARLEN_BYTES = 4;

    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_ESCAPE   = 8'hF7;
    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] ST_PRESSURE = 8'hD0;
    localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd32;

    typedef enum logic [2:0] {
        KIND_CHANNEL = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_TEMPO   = 3'd3,
        KIND_NOTICE  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  status;
        logic [3:0]  channel;
        logic [6:0]  meta_type;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [27:0] delta;
        logic [31:0] onset_time;
        logic [15:0] payload_length;
        logic [23:0] tempo;
        logic        last;
        logic [15:0] track_number;
    } result_t;

endpackage

### rtl/core/mtep_in_if.sv
// Request channel carrying raw track bytes.
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_track;
    logic       last_of_track;

    modport source (output valid, output data_byte, output first_of_track,
                    output last_of_track, input ready);
    modport sink   (input valid, input data_byte, input first_of_track,
                    input last_of_track, output ready);
endinterface

### rtl/core/mtep_out_if.sv
// Request channel carrying decoded track events.
interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  status;
    logic [3:0]  channel;
    logic [6:0]  meta_type;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [27:0] delta;
    logic [31:0] onset_time;
    logic [15:0] payload_length;
    logic [23:0] tempo;
    logic        last;
    logic [15:0] track_number;

    modport source (output valid, output kind, output status, output channel,
                    output meta_type, output data1, output data2, output delta,
                    output onset_time, output payload_length, output tempo,
                    output last, output track_number, input ready);
    modport sink   (input valid, input kind, input status, input channel,
                    input meta_type, input data1, input data2, input delta,
                    input onset_time, input payload_length, input tempo,
                    input last, input track_number, output ready);
endinterface

### rtl/core/midi_track_event_parser.sv
// Top level of the MIDI track event parser.
//
//  port     | dir | handshake    | request content
//  in_ch    | in  | valid/ready  | data_byte, first_of_track, last_of_track
//  out_ch   | out | valid/ready  | one decoded event, payload byte, tempo or notice
//  cfg_we   | in  | write enable | cfg_wdata = payload_limit
//
// One byte per cycle while out_ch does not stall; a result appears in the cycle after its byte is accepted.
// Decode is one pass of logic from the parse state into a single result register.
// A new byte is taken while the result register is empty or being drained.
// A stall on out_ch holds the result and stops input until it is taken.
// Reset clears all parse state and sets payload_limit to 32; no clearing pass.
module midi_track_event_parser (
    input  logic             clk,
    input  logic             rst_n,
    mtep_in_if.sink          in_ch,
    mtep_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata
);

    logic              accept;
    logic              emit;
    logic              res_valid;
    mtep_pkg::result_t result;
    mtep_pkg::result_t res_data;

    // Take a byte when the result slot is free or being drained
    assign in_ch.ready = !res_valid || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    mtep_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (in_ch.data_byte),
        .first_of_track (in_ch.first_of_track),
        .last_of_track  (in_ch.last_of_track),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .emit           (emit),
        .result         (result)
    );

    mtep_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .emit   (emit),
        .result (result),
        .take   (out_ch.ready),
        .valid  (res_valid),
        .data   (res_data)
    );

    // Drive the output channel
    assign out_ch.valid          = res_valid;
    assign out_ch.kind           = res_data.kind;
    assign out_ch.status         = res_data.status;
    assign out_ch.channel        = res_data.channel;
    assign out_ch.meta_type      = res_data.meta_type;
    assign out_ch.data1          = res_data.data1;
    assign out_ch.data2          = res_data.data2;
    assign out_ch.delta          = res_data.delta;
    assign out_ch.onset_time     = res_data.onset_time;
    assign out_ch.payload_length = res_data.payload_length;
    assign out_ch.tempo          = res_data.tempo;
    assign out_ch.last           = res_data.last;
    assign out_ch.track_number   = res_data.track_number;

`ifndef SYNTH
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.kind <= mtep_pkg::KIND_NOTICE)
        else $error("result kind out of range");

    a_notice_bare: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind == mtep_pkg::KIND_NOTICE) |->
        (out_ch.status == 8'd0 && out_ch.payload_length == 16'd0 &&
         out_ch.tempo == 24'd0 && out_ch.last == 1'b0))
        else $error("notice carries event fields");

    a_tempo_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind == mtep_pkg::KIND_TEMPO) |->
        (out_ch.status == mtep_pkg::ST_META &&
         out_ch.meta_type == mtep_pkg::META_TEMPO[6:0]))
        else $error("tempo result without tempo tag");

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind == mtep_pkg::KIND_PAYLOAD) |->
        out_ch.payload_length != 16'd0)
        else $error("payload byte from empty payload");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !emit) |=> !out_ch.valid)
        else $error("stale result after silent byte");
`endif

endmodule

### rtl/core/mtep_core.sv
// Parse state and per-byte decode of track bytes into event results.
module mtep_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               first_of_track,
    input  logic               last_of_track,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    output logic               emit,
    output mtep_pkg::result_t  result
);

    typedef enum logic [3:0] {
        PH_DELTA        = 4'd0,
        PH_STATUS       = 4'd1,
        PH_DATA1        = 4'd2,
        PH_DATA2        = 4'd3,
        PH_SX_LEN       = 4'd4,
        PH_META_TYPE    = 4'd5,
        PH_META_LEN     = 4'd6,
        PH_PAYLOAD      = 4'd7,
        PH_SKIP_PAYLOAD = 4'd8,
        PH_TEMPO        = 4'd9,
        PH_SKIP_TRACK   = 4'd10
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  rstat_reg, rstat_next;
    logic [3:0]  rchan_reg, rchan_next;
    logic [27:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] time_reg, time_next;
    logic [27:0] remain_reg, remain_next;
    logic [7:0]  cstat_reg, cstat_next;
    logic [7:0]  cmeta_reg, cmeta_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] track_reg, track_next;
    logic [27:0] edelta_reg, edelta_next;
    logic [15:0] limit_reg;

    logic [27:0] acc_fed;
    logic [2:0]  cnt_fed;
    logic        vl_done;
    logic [27:0] remain_dec;
    logic [23:0] tempo_acc;

    // Decode one byte: state update and result
    always_comb
    begin
        phase_next  = phase_reg;
        rstat_next  = rstat_reg;
        rchan_next  = rchan_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        time_next   = time_reg;
        remain_next = remain_reg;
        cstat_next  = cstat_reg;
        cmeta_next  = cmeta_reg;
        held_next   = held_reg;
        track_next  = track_reg;
        edelta_next = edelta_reg;
        emit        = 1'b0;
        result      = '0;

        // Restart parsing at a new track
        if (first_of_track)
        begin
            if (track_reg != 16'hFFFF)
                track_next = track_reg + 16'd1;
            rstat_next = '0;
            rchan_next = '0;
            time_next  = '0;
            phase_next = PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
        end

        acc_fed    = {acc_next[20:0], data_byte[6:0]};
        cnt_fed    = cnt_next + 3'd1;
        vl_done    = !data_byte[7] ||
                     (cnt_fed >= 3'(mtep_pkg::MAX_VARLEN_BYTES));
        remain_dec = remain_next - 28'd1;
        tempo_acc  = {acc_next[15:0], data_byte};

        result.delta        = edelta_reg;
        result.onset_time   = time_next;
        result.track_number = track_next;

        unique case (phase_next)
            PH_DELTA:
            begin
                acc_next = acc_fed;
                cnt_next = cnt_fed;
                if (vl_done)
                begin
                    edelta_next = acc_fed;
                    time_next   = time_next + {4'd0, acc_fed};
                    phase_next  = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (!data_byte[7])
                begin
                    if (rstat_next[7] && rstat_next[7:4] != 4'hF)
                    begin
                        cstat_next = rstat_next;
                        held_next  = data_byte;
                        if (rstat_next == mtep_pkg::ST_PROGRAM ||
                            rstat_next == mtep_pkg::ST_PRESSURE)
                        begin
                            emit           = 1'b1;
                            result.kind    = mtep_pkg::KIND_CHANNEL;
                            result.status  = rstat_next;
                            result.channel = rchan_next;
                            result.data1   = data_byte;
                            phase_next     = PH_DELTA;
                            acc_next       = '0;
                            cnt_next       = '0;
                        end
                        else
                            phase_next = PH_DATA2;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        result.kind = mtep_pkg::KIND_NOTICE;
                        phase_next  = PH_SKIP_TRACK;
                    end
                end
                else if (data_byte[7:4] != 4'hF)
                begin
                    rstat_next = {data_byte[7:4], 4'h0};
                    rchan_next = data_byte[3:0];
                    cstat_next = {data_byte[7:4], 4'h0};
                    phase_next = PH_DATA1;
                end
                else if (data_byte == mtep_pkg::ST_SYSEX ||
                         data_byte == mtep_pkg::ST_ESCAPE)
                begin
                    rstat_next = '0;
                    cstat_next = data_byte;
                    cmeta_next = '0;
                    phase_next = PH_SX_LEN;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else if (data_byte == mtep_pkg::ST_META)
                begin
                    rstat_next = '0;
                    cstat_next = data_byte;
                    phase_next = PH_META_TYPE;
                end
                else
                begin
                    emit        = 1'b1;
                    result.kind = mtep_pkg::KIND_NOTICE;
                    phase_next  = PH_SKIP_TRACK;
                end
            end
            PH_DATA1:
            begin
                held_next = data_byte;
                if (cstat_next == mtep_pkg::ST_PROGRAM ||
                    cstat_next == mtep_pkg::ST_PRESSURE)
                begin
                    emit           = 1'b1;
                    result.kind    = mtep_pkg::KIND_CHANNEL;
                    result.status  = cstat_next;
                    result.channel = rchan_next;
                    result.data1   = data_byte;
                    phase_next     = PH_DELTA;
                    acc_next       = '0;
                    cnt_next       = '0;
                end
                else
                    phase_next = PH_DATA2;
            end
            PH_DATA2:
            begin
                emit           = 1'b1;
                result.kind    = mtep_pkg::KIND_CHANNEL;
                result.status  = cstat_next;
                result.channel = rchan_next;
                result.data1   = held_next;
                result.data2   = data_byte;
                phase_next     = PH_DELTA;
                acc_next       = '0;
                cnt_next       = '0;
            end
            PH_SX_LEN, PH_META_LEN:
            begin
                acc_next = acc_fed;
                cnt_next = cnt_fed;
                if (vl_done)
                begin
                    if (phase_next == PH_META_LEN && cmeta_next[7])
                    begin
                        // Drop payload of a meta type above 127
                        if (acc_fed == '0)
                        begin
                            phase_next = PH_DELTA;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            remain_next = acc_fed;
                            phase_next  = PH_SKIP_PAYLOAD;
                        end
                    end
                    else if (phase_next == PH_META_LEN &&
                             cmeta_next == mtep_pkg::META_EOT && acc_fed != '0)
                    begin
                        emit        = 1'b1;
                        result.kind = mtep_pkg::KIND_NOTICE;
                        phase_next  = PH_SKIP_TRACK;
                    end
                    else if (phase_next == PH_META_LEN &&
                             cmeta_next == mtep_pkg::META_TEMPO)
                    begin
                        if (acc_fed != 28'd3)
                        begin
                            emit        = 1'b1;
                            result.kind = mtep_pkg::KIND_NOTICE;
                            phase_next  = PH_SKIP_TRACK;
                        end
                        else
                        begin
                            remain_next = 28'd3;
                            acc_next    = '0;
                            phase_next  = PH_TEMPO;
                        end
                    end
                    else if (acc_fed > {12'd0, limit_reg})
                    begin
                        // Skip an oversize payload quietly
                        remain_next = acc_fed;
                        phase_next  = PH_SKIP_PAYLOAD;
                    end
                    else
                    begin
                        emit                  = 1'b1;
                        result.kind           = mtep_pkg::KIND_HEADER;
                        result.status         = cstat_next;
                        result.meta_type      = cmeta_next[6:0];
                        result.payload_length = acc_fed[15:0];
                        if (acc_fed == '0)
                        begin
                            phase_next = PH_DELTA;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            remain_next = acc_fed;
                            phase_next  = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_META_TYPE:
            begin
                cmeta_next = data_byte;
                phase_next = PH_META_LEN;
                acc_next   = '0;
                cnt_next   = '0;
            end
            PH_PAYLOAD:
            begin
                remain_next           = remain_dec;
                emit                  = 1'b1;
                result.kind           = mtep_pkg::KIND_PAYLOAD;
                result.status         = cstat_next;
                result.meta_type      = cmeta_next[6:0];
                result.data1          = data_byte;
                result.payload_length = acc_next[15:0];
                result.last           = (remain_dec == '0);
                if (remain_dec == '0)
                begin
                    phase_next = PH_DELTA;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            end
            PH_SKIP_PAYLOAD:
            begin
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    phase_next = PH_DELTA;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
            end
            PH_TEMPO:
            begin
                acc_next    = {4'd0, tempo_acc};
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    emit             = 1'b1;
                    result.kind      = mtep_pkg::KIND_TEMPO;
                    result.status    = mtep_pkg::ST_META;
                    result.meta_type = mtep_pkg::META_TEMPO[6:0];
                    result.tempo     = tempo_acc;
                    phase_next       = PH_DELTA;
                    acc_next         = '0;
                    cnt_next         = '0;
                end
            end
            PH_SKIP_TRACK:
            begin
                phase_next = PH_SKIP_TRACK;
            end
            default:
            begin
                phase_next = PH_DELTA;
                acc_next   = '0;
                cnt_next   = '0;
            end
        endcase

        // Wait for a delta after the track ends
        if (last_of_track)
        begin
            phase_next = PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
        end
    end

    // Hold parse state; advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DELTA;
            rstat_reg  <= '0;
            rchan_reg  <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            time_reg   <= '0;
            remain_reg <= '0;
            cstat_reg  <= '0;
            cmeta_reg  <= '0;
            held_reg   <= '0;
            track_reg  <= '0;
            edelta_reg <= '0;
            limit_reg  <= mtep_pkg::PAYLOAD_LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg  <= phase_next;
                rstat_reg  <= rstat_next;
                rchan_reg  <= rchan_next;
                acc_reg    <= acc_next;
                cnt_reg    <= cnt_next;
                time_reg   <= time_next;
                remain_reg <= remain_next;
                cstat_reg  <= cstat_next;
                cmeta_reg  <= cmeta_next;
                held_reg   <= held_next;
                track_reg  <= track_next;
                edelta_reg <= edelta_next;
            end
        end
    end

endmodule

### rtl/core/mtep_out_reg.sv
// Result register between the decode logic and the output channel.
module mtep_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               emit,
    input  mtep_pkg::result_t  result,
    input  logic               take,
    output logic               valid,
    output mtep_pkg::result_t  data
);

    logic              valid_reg, valid_next;
    mtep_pkg::result_t data_reg;

    // Refill on an accepted byte, drain when taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = emit;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture payload with each accepted byte that emits a result
    always_ff @(posedge clk)
    begin
        if (load && emit)
            data_reg <= result;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule
